[rtl/qme_pkg.sv]
`default_nettype none

package qme_pkg;

   localparam int LOG_FRAC = 16;
   localparam logic [23:0] OUT_MAX = 24'hFFFFFF;

   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 16;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ESCAPE_THRESHOLD = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_ITERATION_LIMIT  = 2'd1;

   // multiply schedule of one quartic step
   typedef enum logic [2:0] {
      OP_SQ_X,
      OP_SQ_Y,
      OP_XY,
      OP_XX,
      OP_YY,
      OP_X2Y2,
      OP_XY_X2,
      OP_XY_Y2
   } op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_START,
      ST_MUL_WAIT,
      ST_CHECK,
      ST_UPDATE,
      ST_EVAL,
      ST_NORM1,
      ST_LCHK,
      ST_NORM2,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic        start;
      logic [63:0] a;
      logic [63:0] b;
   } mul_req_type;

   typedef struct packed {
      logic done;
      logic neg;
   } mul_rsp_type;

endpackage

`default_nettype wire

[rtl/quartic_multibrot_escape_time.sv]
`default_nettype none

// channel   direction  handshake              payload
// req       in         req_valid / req_stall  req_point_re, req_point_im (Q4.28 by default)
// rsp       out        rsp_valid / rsp_stall  rsp_smooth_count (Q16.8), rsp_escaped
// csr       in         csr_write              csr_index, csr_data
//
// one point at a time: each quartic step takes eight 64 by 64 multiplies on the
// shared multiplier, and an item ends with up to two one-bit-a-cycle normalising
// log passes.
// reset is synchronous and restores both registers; no clearing pass is needed.
// a finished result waits in the output register while the next point is taken.

module quartic_multibrot_escape_time #(
   parameter int FRAC_BITS         = 28,
   parameter int LOG_TABLE_ENTRIES = 256
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic signed [31:0]                  req_point_re,
   input  wire logic signed [31:0]                  req_point_im,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic [23:0]                              rsp_smooth_count,
   output logic                                     rsp_escaped,
   input  wire logic                                csr_write,
   input  wire logic [qme_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [qme_pkg::CSR_DATA_BITS-1:0]   csr_data
);

   localparam int IDX_BITS = $clog2(LOG_TABLE_ENTRIES);
   localparam int LOG_W    = 7 + qme_pkg::LOG_FRAC;
   localparam logic signed [24:0] LOG_OFS_MAG = 25'(2 * FRAC_BITS * 65536);
   localparam logic signed [24:0] LOG_OFS_L   = 25'(qme_pkg::LOG_FRAC * 65536);

   function automatic logic [LOG_TABLE_ENTRIES-1:0][15:0] build_log_table();
      logic [LOG_TABLE_ENTRIES-1:0][15:0] t;
      logic [63:0] y;
      logic [15:0] r;
      for (int i = 0; i < LOG_TABLE_ENTRIES; i++) begin
         y = (64'(LOG_TABLE_ENTRIES + i) << 30) / 64'(LOG_TABLE_ENTRIES);
         r = 16'd0;
         for (int k = 0; k < qme_pkg::LOG_FRAC; k++) begin
            y = (y * y) >> 30;
            r = {r[14:0], 1'b0};
            if (y >= (64'd2 << 30)) begin
               y    = y >> 1;
               r[0] = 1'b1;
            end
         end
         t[i] = r;
      end
      return t;
   endfunction

   localparam logic [LOG_TABLE_ENTRIES-1:0][15:0] LOG_TBL = build_log_table();

   qme_pkg::state_type   state_ff, state_in;
   qme_pkg::op_type      op_ff;
   qme_pkg::mul_req_type mul_req;
   qme_pkg::mul_rsp_type mul_rsp;
   logic [127:0]         mul_prod;

   logic [6:0]   thr_ff;
   logic [15:0]  limit_ff;
   logic         rsp_valid_ff, rsp_valid_in;
   logic [23:0]  rsp_count_ff;
   logic         rsp_esc_ff;

   logic signed [31:0] cx_ff, cy_ff;
   logic [63:0]  zx_ff, zy_ff;
   logic [15:0]  n_ff;
   logic [127:0] sqx_ff, sqy_ff, mag2_ff;
   logic [63:0]  xy_ff, pxx_ff, pyy_ff, pxy_ff, pa_ff, pb_ff;
   logic [127:0] norm_ff;
   logic [6:0]   pos_ff;
   logic signed [24:0] l_ff;
   logic [23:0]  res_ff;
   logic         esc_ff;

   logic [127:0] mag2, thr_wide, prod_shr;
   logic [63:0]  x2, y2, fm, cx64, cy64, re_next, im_next;
   logic         cont, esc_now, norm_stop, load_rsp;
   logic [63:0]  idx_prod;
   logic [IDX_BITS-1:0] tbl_idx;
   logic [LOG_W-1:0] log_val;
   logic signed [24:0] l_val, ll_val;
   logic signed [35:0] r_val;

   assign x2       = sqx_ff[FRAC_BITS +: 64];
   assign y2       = sqy_ff[FRAC_BITS +: 64];
   assign prod_shr = mul_prod >> FRAC_BITS;
   assign fm       = mul_rsp.neg ? 64'd0 - prod_shr[63:0] : prod_shr[63:0];
   assign mag2     = sqx_ff + sqy_ff;
   assign thr_wide = 128'(thr_ff) << (2 * FRAC_BITS);
   assign cont     = (mag2 < thr_wide) && (n_ff < limit_ff);
   assign esc_now  = n_ff < limit_ff;
   assign cx64     = {{32{cx_ff[31]}}, cx_ff};
   assign cy64     = {{32{cy_ff[31]}}, cy_ff};
   assign re_next  = pxx_ff + pyy_ff - ((pxy_ff << 2) + (pxy_ff << 1)) + cx64;
   assign im_next  = (pa_ff << 2) - (pb_ff << 2) + cy64;

   // log2 = msb position in the integer part, table entry below it
   // table index scales the 32-bit mantissa fraction by the table size
   assign norm_stop = norm_ff[127] || (pos_ff == 7'd0);
   assign idx_prod  = 64'(norm_ff[126 -: 32]) * 64'(LOG_TABLE_ENTRIES);
   assign tbl_idx   = idx_prod[32 +: IDX_BITS];
   assign log_val   = {pos_ff, LOG_TBL[tbl_idx]};
   assign l_val     = 25'(log_val) - LOG_OFS_MAG;
   assign ll_val    = 25'(log_val) - LOG_OFS_L;
   assign r_val     = (36'(n_ff) << 17) + 36'sd327680 - 36'(ll_val);

   assign load_rsp = (state_ff == qme_pkg::ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   qme_mul u_mul (
      .clock    (clock),
      .reset    (reset),
      .mul_req  (mul_req),
      .mul_rsp  (mul_rsp),
      .mul_prod (mul_prod)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         qme_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = qme_pkg::ST_MUL_START;
            end
         end
         qme_pkg::ST_MUL_START: state_in = qme_pkg::ST_MUL_WAIT;
         qme_pkg::ST_MUL_WAIT: begin
            if (mul_rsp.done) begin
               if (op_ff == qme_pkg::OP_SQ_Y) begin
                  state_in = qme_pkg::ST_CHECK;
               end else if (op_ff == qme_pkg::OP_XY_Y2) begin
                  state_in = qme_pkg::ST_UPDATE;
               end else begin
                  state_in = qme_pkg::ST_MUL_START;
               end
            end
         end
         qme_pkg::ST_CHECK:  state_in = cont ? qme_pkg::ST_MUL_START : qme_pkg::ST_EVAL;
         qme_pkg::ST_UPDATE: state_in = qme_pkg::ST_MUL_START;
         qme_pkg::ST_EVAL: begin
            if (!esc_now || (mag2_ff == 128'd0)) begin
               state_in = qme_pkg::ST_DONE;
            end else begin
               state_in = qme_pkg::ST_NORM1;
            end
         end
         qme_pkg::ST_NORM1: begin
            if (norm_stop) begin
               state_in = qme_pkg::ST_LCHK;
            end
         end
         qme_pkg::ST_LCHK: begin
            if (l_ff <= 25'sd0) begin
               state_in = qme_pkg::ST_DONE;
            end else begin
               state_in = qme_pkg::ST_NORM2;
            end
         end
         qme_pkg::ST_NORM2: begin
            if (norm_stop) begin
               state_in = qme_pkg::ST_DONE;
            end
         end
         qme_pkg::ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               state_in = qme_pkg::ST_IDLE;
            end
         end
         default: state_in = qme_pkg::ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_stall     = (state_ff != qme_pkg::ST_IDLE);
      mul_req.start = (state_ff == qme_pkg::ST_MUL_START);
      case (op_ff)
         qme_pkg::OP_SQ_X:  begin mul_req.a = zx_ff; mul_req.b = zx_ff; end
         qme_pkg::OP_SQ_Y:  begin mul_req.a = zy_ff; mul_req.b = zy_ff; end
         qme_pkg::OP_XY:    begin mul_req.a = zx_ff; mul_req.b = zy_ff; end
         qme_pkg::OP_XX:    begin mul_req.a = x2;    mul_req.b = x2;    end
         qme_pkg::OP_YY:    begin mul_req.a = y2;    mul_req.b = y2;    end
         qme_pkg::OP_X2Y2:  begin mul_req.a = x2;    mul_req.b = y2;    end
         qme_pkg::OP_XY_X2: begin mul_req.a = xy_ff; mul_req.b = x2;    end
         default:           begin mul_req.a = xy_ff; mul_req.b = y2;    end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= qme_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         thr_ff       <= 7'd16;
         limit_ff     <= 16'd256;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write) begin
            case (csr_index)
               qme_pkg::CSR_ESCAPE_THRESHOLD: thr_ff   <= csr_data[6:0];
               qme_pkg::CSR_ITERATION_LIMIT:  limit_ff <= csr_data;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_rsp) begin
         rsp_count_ff <= res_ff;
         rsp_esc_ff   <= esc_ff;
      end
      case (state_ff)
         qme_pkg::ST_IDLE: begin
            cx_ff <= req_point_re;
            cy_ff <= req_point_im;
            zx_ff <= 64'(req_point_re);
            zy_ff <= 64'(req_point_im);
            n_ff  <= 16'd1;
            op_ff <= qme_pkg::OP_SQ_X;
         end
         qme_pkg::ST_MUL_WAIT: begin
            if (mul_rsp.done) begin
               case (op_ff)
                  qme_pkg::OP_SQ_X:  sqx_ff <= mul_prod;
                  qme_pkg::OP_SQ_Y:  sqy_ff <= mul_prod;
                  qme_pkg::OP_XY:    xy_ff  <= fm;
                  qme_pkg::OP_XX:    pxx_ff <= fm;
                  qme_pkg::OP_YY:    pyy_ff <= fm;
                  qme_pkg::OP_X2Y2:  pxy_ff <= fm;
                  qme_pkg::OP_XY_X2: pa_ff  <= fm;
                  default:           pb_ff  <= fm;
               endcase
               if (op_ff != qme_pkg::OP_SQ_Y && op_ff != qme_pkg::OP_XY_Y2) begin
                  op_ff <= qme_pkg::op_type'(op_ff + 3'd1);
               end
            end
         end
         qme_pkg::ST_CHECK: begin
            mag2_ff <= mag2;
            op_ff   <= qme_pkg::OP_XY;
         end
         qme_pkg::ST_UPDATE: begin
            zx_ff <= re_next;
            zy_ff <= im_next;
            n_ff  <= n_ff + 16'd1;
            op_ff <= qme_pkg::OP_SQ_X;
         end
         qme_pkg::ST_EVAL: begin
            esc_ff  <= esc_now;
            norm_ff <= mag2_ff;
            pos_ff  <= 7'd127;
            if (!esc_now) begin
               res_ff <= {n_ff, 8'd0};
            end else begin
               res_ff <= 24'd0;
            end
         end
         qme_pkg::ST_NORM1: begin
            if (norm_stop) begin
               l_ff <= l_val;
            end else begin
               norm_ff <= norm_ff << 1;
               pos_ff  <= pos_ff - 7'd1;
            end
         end
         qme_pkg::ST_LCHK: begin
            norm_ff <= 128'(l_ff[23:0]);
            pos_ff  <= 7'd127;
            if (l_ff < 25'sd0) begin
               res_ff <= 24'd0;
            end else if (l_ff == 25'sd0) begin
               res_ff <= qme_pkg::OUT_MAX;
            end
         end
         qme_pkg::ST_NORM2: begin
            if (norm_stop) begin
               // saturate both ends
               if (r_val < 36'sd0) begin
                  res_ff <= 24'd0;
               end else if (r_val[35:9] > 27'(qme_pkg::OUT_MAX)) begin
                  res_ff <= qme_pkg::OUT_MAX;
               end else begin
                  res_ff <= r_val[32:9];
               end
            end else begin
               norm_ff <= norm_ff << 1;
               pos_ff  <= pos_ff - 7'd1;
            end
         end
         default: ;
      endcase
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_smooth_count = rsp_count_ff;
   assign rsp_escaped      = rsp_esc_ff;

endmodule

`default_nettype wire

[rtl/qme_mul.sv]
`default_nettype none

module qme_mul (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire qme_pkg::mul_req_type mul_req,
   output qme_pkg::mul_rsp_type      mul_rsp,
   output logic [127:0]              mul_prod
);

   logic        run_ff, run_in;
   logic [1:0]  step_ff, step_in;
   logic        pp_vld_ff, pp_vld_in;
   logic        done_ff, done_in;
   logic        neg_ff;
   logic [63:0] ma_ff, mb_ff;
   logic [63:0] pp_ff;
   logic [1:0]  sel_ff;
   logic [127:0] acc_ff;
   logic [31:0] a_part, b_part;
   logic [127:0] pp_shifted;

   // magnitude times magnitude, four 32 by 32 partial products
   assign a_part = step_ff[1] ? ma_ff[63:32] : ma_ff[31:0];
   assign b_part = step_ff[0] ? mb_ff[63:32] : mb_ff[31:0];

   always_comb begin
      case (sel_ff)
         2'd0:    pp_shifted = {64'd0, pp_ff};
         2'd1:    pp_shifted = {32'd0, pp_ff, 32'd0};
         2'd2:    pp_shifted = {32'd0, pp_ff, 32'd0};
         default: pp_shifted = {pp_ff, 64'd0};
      endcase
   end

   always_comb begin
      run_in    = run_ff;
      step_in   = step_ff;
      pp_vld_in = run_ff;
      done_in   = pp_vld_ff && (sel_ff == 2'd3);
      if (mul_req.start) begin
         run_in  = 1'b1;
         step_in = 2'd0;
      end else if (run_ff) begin
         step_in = step_ff + 2'd1;
         if (step_ff == 2'd3) begin
            run_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff    <= 1'b0;
         step_ff   <= 2'd0;
         pp_vld_ff <= 1'b0;
         done_ff   <= 1'b0;
      end else begin
         run_ff    <= run_in;
         step_ff   <= step_in;
         pp_vld_ff <= pp_vld_in;
         done_ff   <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      if (mul_req.start) begin
         ma_ff  <= mul_req.a[63] ? 64'd0 - mul_req.a : mul_req.a;
         mb_ff  <= mul_req.b[63] ? 64'd0 - mul_req.b : mul_req.b;
         neg_ff <= mul_req.a[63] ^ mul_req.b[63];
         acc_ff <= 128'd0;
      end else begin
         if (run_ff) begin
            pp_ff  <= a_part * b_part;
            sel_ff <= step_ff;
         end
         if (pp_vld_ff) begin
            acc_ff <= acc_ff + pp_shifted;
         end
      end
   end

   assign mul_rsp.done = done_ff;
   assign mul_rsp.neg  = neg_ff;
   assign mul_prod     = acc_ff;

endmodule

`default_nettype wire

[bench/tb_top.sv]
`default_nettype none

module tb_top;

   localparam int FRAC = 28;
   localparam int TABLE_SIZE = 256;
   localparam int CYCLE_LIMIT = 4000000;
   localparam logic [qme_pkg::CSR_INDEX_BITS-1:0] CSR_SPARE_A = 2'd2;
   localparam logic [qme_pkg::CSR_INDEX_BITS-1:0] CSR_SPARE_B = 2'd3;
   localparam logic [31:0] ONE = 32'h1000_0000;

   typedef struct {
      logic [23:0] smooth_count;
      logic        escaped;
   } escape_result_type;

   class escape_scoreboard_type;
      logic [6:0]        threshold;
      logic [15:0]       limit;
      longint            log_frac_q16[TABLE_SIZE];
      escape_result_type due[$];
      int                fails;

      function new();
         longint unsigned y;
         longint r;
         for (int i = 0; i < TABLE_SIZE; i++) begin
            y = ((64'(TABLE_SIZE) + 64'(i)) << 30) / 64'(TABLE_SIZE);
            r = 0;
            for (int k = 0; k < qme_pkg::LOG_FRAC; k++) begin
               y = (y * y) >> 30;
               r = r << 1;
               if (y >= (64'd2 << 30)) begin
                  y = y >> 1;
                  r = r | 1;
               end
            end
            log_frac_q16[i] = r;
         end
         threshold = 7'd16;
         limit = 16'd256;
         fails = 0;
      endfunction

      function void write_reg(logic [qme_pkg::CSR_INDEX_BITS-1:0] idx,
                              logic [qme_pkg::CSR_DATA_BITS-1:0] d);
         if (idx == qme_pkg::CSR_ESCAPE_THRESHOLD) threshold = d[6:0];
         else if (idx == qme_pkg::CSR_ITERATION_LIMIT) limit = d;
      endfunction

      function logic [63:0] magnitude(logic [63:0] v);
         return v[63] ? -v : v;
      endfunction

      function logic [63:0] fx_mul(logic [63:0] a, logic [63:0] b);
         logic [127:0] p;
         logic [63:0] r;
         p = {64'b0, magnitude(a)} * {64'b0, magnitude(b)};
         r = p[FRAC+63:FRAC];
         return (a[63] ^ b[63]) ? -r : r;
      endfunction

      function logic [127:0] norm_sq(logic [63:0] x, logic [63:0] y);
         logic [127:0] a, b;
         a = {64'b0, magnitude(x)};
         b = {64'b0, magnitude(y)};
         return a * a + b * b;
      endfunction

      // integer log2 in q.16 from the leading one and the table
      function longint log2_q16(logic [127:0] v);
         int p;
         logic [127:0] sh;
         p = 127;
         while (p > 0 && !v[p]) p--;
         sh = v << (127 - p);
         return longint'(p) * 65536 + log_frac_q16[sh[126:119]];
      endfunction

      function void note(logic [31:0] re, logic [31:0] im);
         logic [63:0] cx, cy, zx, zy, x2, y2, xy, n;
         logic [127:0] thr, m;
         longint lv, ll, r;
         escape_result_type e;
         cx = {{32{re[31]}}, re};
         cy = {{32{im[31]}}, im};
         thr = {121'b0, threshold} << (2 * FRAC);
         zx = cx;
         zy = cy;
         n = 1;
         while (norm_sq(zx, zy) < thr && n < limit) begin
            x2 = fx_mul(zx, zx);
            y2 = fx_mul(zy, zy);
            xy = fx_mul(zx, zy);
            zx = fx_mul(x2, x2) + fx_mul(y2, y2) - 64'd6 * fx_mul(x2, y2) + cx;
            zy = 64'd4 * fx_mul(xy, x2) - 64'd4 * fx_mul(xy, y2) + cy;
            n++;
         end
         e.escaped = (n < limit);
         if (!e.escaped) begin
            e.smooth_count = 24'(n << 8);
         end else begin
            m = norm_sq(zx, zy);
            if (m == 0) begin
               e.smooth_count = 0;
            end else begin
               lv = log2_q16(m) - longint'(2 * FRAC) * 65536;
               if (lv < 0) e.smooth_count = 0;
               else if (lv == 0) e.smooth_count = qme_pkg::OUT_MAX;
               else begin
                  ll = log2_q16({64'b0, lv}) - longint'(qme_pkg::LOG_FRAC) * 65536;
                  r = longint'(n) * 131072 + 327680 - ll;
                  if (r < 0) e.smooth_count = 0;
                  else if ((r >>> 9) > longint'(qme_pkg::OUT_MAX))
                     e.smooth_count = qme_pkg::OUT_MAX;
                  else e.smooth_count = 24'(r >>> 9);
               end
            end
         end
         due.push_back(e);
      endfunction

      function void check(logic [23:0] smooth_count, logic escaped);
         escape_result_type e;
         if (due.size() == 0) begin
            $error("result with nothing expected: smooth_count %h escaped %b",
                   smooth_count, escaped);
            fails++;
            return;
         end
         e = due.pop_front();
         if (smooth_count !== e.smooth_count) begin
            $error("smooth_count expected %h actual %h", e.smooth_count, smooth_count);
            fails++;
         end
         if (escaped !== e.escaped) begin
            $error("escaped expected %b actual %b", e.escaped, escaped);
            fails++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic signed [31:0] req_point_re = 0;
   logic signed [31:0] req_point_im = 0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic [23:0] rsp_smooth_count;
   logic rsp_escaped;
   logic csr_write = 0;
   logic [qme_pkg::CSR_INDEX_BITS-1:0] csr_index = 0;
   logic [qme_pkg::CSR_DATA_BITS-1:0] csr_data = 0;

   escape_scoreboard_type orbit_sb = new();
   bit calm = 0;
   int stall_left = 0;
   int cycles = 0;

   quartic_multibrot_escape_time uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_point_re(req_point_re), .req_point_im(req_point_im),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_smooth_count(rsp_smooth_count), .rsp_escaped(rsp_escaped),
      .csr_write(csr_write), .csr_index(csr_index), .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb_top failed");
         $finish;
      end
   end

   // receiver stalls in bursts
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(0, 13);
         rsp_stall <= 1;
      end else begin
         rsp_stall <= 0;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) orbit_sb.check(rsp_smooth_count, rsp_escaped);
   end

   task automatic send_point(logic [31:0] re, logic [31:0] im);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid <= 1;
      req_point_re <= re;
      req_point_im <= im;
      do @(posedge clock); while (req_stall);
      orbit_sb.note(re, im);
   endtask

   task automatic write_csr(logic [qme_pkg::CSR_INDEX_BITS-1:0] idx,
                            logic [qme_pkg::CSR_DATA_BITS-1:0] d);
      req_valid <= 0;
      while (orbit_sb.due.size() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_write <= 1;
      csr_index <= idx;
      csr_data <= d;
      @(posedge clock);
      orbit_sb.write_reg(idx, d);
      csr_write <= 0;
   endtask

   // mostly points near the set, where escape counts vary
   task automatic random_point();
      logic [31:0] re, im;
      int sel;
      sel = $urandom_range(0, 9);
      if (sel < 7) begin
         re = $urandom_range(0, 32'h3333_3332) - 32'h1999_9999;
         im = $urandom_range(0, 32'h3333_3332) - 32'h1999_9999;
      end else if (sel < 9) begin
         re = $urandom;
         im = $urandom;
      end else begin
         re = $urandom_range(0, 32'h0200_0000) - 32'h0100_0000;
         im = $urandom;
      end
      send_point(re, im);
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // reset settings: origin and minus one stay inside, one and i escape quickly
      send_point(32'h0, 32'h0);
      send_point(32'h8000_0000, 32'h8000_0000);
      send_point(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_point(32'h8000_0000, 32'h0);
      send_point(32'h0, 32'h7FFF_FFFF);
      send_point(ONE, 32'h0);
      send_point(-ONE, 32'h0);
      send_point(32'h0, ONE);
      send_point(32'h1, 32'hFFFF_FFFF);

      // zero threshold: zero magnitude, magnitude one, below one, above one
      write_csr(qme_pkg::CSR_ESCAPE_THRESHOLD, 16'd0);
      send_point(32'h0, 32'h0);
      send_point(ONE, 32'h0);
      send_point(32'h0800_0000, 32'h0);
      send_point(32'h3000_0000, 32'h0);
      write_csr(qme_pkg::CSR_ITERATION_LIMIT, 16'd1);
      send_point(32'h0, 32'h0);
      send_point(32'h3000_0000, 32'h0);

      // zero limit, widest threshold with the upper data bits set
      write_csr(qme_pkg::CSR_ESCAPE_THRESHOLD, 16'hFF7F);
      write_csr(qme_pkg::CSR_ITERATION_LIMIT, 16'd0);
      send_point(32'h0, 32'h0);
      send_point(32'h7FFF_FFFF, 32'h8000_0000);
      write_csr(CSR_SPARE_A, 16'hFFFF);
      write_csr(CSR_SPARE_B, 16'h0001);
      send_point(ONE, ONE);

      // largest limit, only points that leave fast
      write_csr(qme_pkg::CSR_ESCAPE_THRESHOLD, 16'd64);
      write_csr(qme_pkg::CSR_ITERATION_LIMIT, 16'hFFFF);
      for (int i = 0; i < 5; i++) begin
         send_point($urandom_range(0, 1) ? 32'h2000_0000 + $urandom_range(0, 32'h5FFF_FFFF)
                                         : 32'hE000_0000 - $urandom_range(0, 32'h6000_0000),
                    $urandom);
      end

      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: begin
               write_csr(qme_pkg::CSR_ESCAPE_THRESHOLD, 16'd1);
               write_csr(qme_pkg::CSR_ITERATION_LIMIT, 16'd2);
            end
            1: begin
               write_csr(qme_pkg::CSR_ESCAPE_THRESHOLD, 16'd127);
               write_csr(qme_pkg::CSR_ITERATION_LIMIT, 16'd40);
            end
            default: begin
               write_csr(qme_pkg::CSR_ESCAPE_THRESHOLD, 16'($urandom_range(1, 127)));
               write_csr(qme_pkg::CSR_ITERATION_LIMIT, 16'($urandom_range(2, 48)));
            end
         endcase
         for (int i = 0; i < 44; i++) begin
            if (ph == 5 && i >= 4) calm = 1;
            random_point();
         end
      end

      req_valid <= 0;
      while (orbit_sb.due.size() > 0) @(posedge clock);
      repeat (300) @(posedge clock);
      if (orbit_sb.fails == 0) $display("tb_top passed");
      else $display("tb_top failed");
      $finish;
   end

endmodule

`default_nettype wire
